// File: hw/rtl/hket_pkg.sv
// shared types and constants of the held key event table
package hket_pkg;

  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned KEYCODE_W = 16;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned OWNER_W   = 32;

  // request opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT     = 3'd0,
    OP_REMOVE_KEY = 3'd1,
    OP_RELEASE    = 3'd2,
    OP_QUERY      = 3'd3,
    OP_REMOVE_OWN = 3'd4
  } op_e;

  // result kinds
  localparam logic KIND_DONE  = 1'b0;
  localparam logic KIND_KEYUP = 1'b1;

  // one stored entry
  typedef struct packed {
    logic [KEYCODE_W-1:0] key_code;
    logic [KEY_W-1:0]     key_ref;
    logic [OWNER_W-1:0]   owner_tag;
  } entry_t;

endpackage

// File: hw/rtl/hket_if.sv
// request and result channel interfaces of the held key event table
interface hket_in_if import hket_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [KEYCODE_W-1:0] key_code;
  logic [KEY_W-1:0]     key_ref;
  logic [OWNER_W-1:0]   owner_tag;

  modport source (output valid, opcode, key_code, key_ref, owner_tag, input ready);
  modport sink   (input valid, opcode, key_code, key_ref, owner_tag, output ready);
endinterface

interface hket_out_if import hket_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 result_kind;
  logic                 hit;
  logic [KEYCODE_W-1:0] out_keycode;
  logic [KEY_W-1:0]     out_key;
  logic                 last;

  modport source (output valid, result_kind, hit, out_keycode, out_key, last, input ready);
  modport sink   (input valid, result_kind, hit, out_keycode, out_key, last, output ready);
endinterface

// File: hw/rtl/hket_link_mem.sv
// link memory with per-slot written flags standing in for the reset chain
module hket_link_mem #(
  parameter int unsigned SLOTS = 16,
  localparam int unsigned LW = $clog2(SLOTS + 1),
  localparam int unsigned IW = $clog2(SLOTS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic [IW-1:0] raddr_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  logic [LW-1:0] wdata_i,
  output logic [LW-1:0] rdata_o
);

  localparam logic [LW-1:0] SLOT_END = LW'(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  logic [LW-1:0]    mem [SLOTS];
  logic [SLOTS-1:0] written_q;
  logic [LW-1:0]    rdata_q;
  logic             rd_written_q;
  logic [IW-1:0]    rd_addr_q;
  logic [LW-1:0]    init_link;

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q      <= mem[raddr_i];
      rd_written_q <= written_q[raddr_i];
      rd_addr_q    <= raddr_i;
    end
  end

  // written flags, cleared at once by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (we_i) begin
      written_q[waddr_i] <= 1'b1;
    end
  end

  // reset chain: slot i links to i+1, the last slot and the sentinel to end
  always_comb begin
    if (rd_addr_q == LAST_IDX || rd_addr_q == '0) begin
      init_link = SLOT_END;
    end else begin
      init_link = LW'(rd_addr_q) + LW'(1);
    end
  end

  assign rdata_o = rd_written_q ? rdata_q : init_link;

endmodule

// File: hw/rtl/hket_data_mem.sv
// entry data memory: keycode, key and owner of each slot
module hket_data_mem import hket_pkg::*; #(
  parameter int unsigned SLOTS = 16,
  localparam int unsigned IW = $clog2(SLOTS)
) (
  input  logic          clk_i,
  input  logic          re_i,
  input  logic [IW-1:0] raddr_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  entry_t        wdata_i,
  output entry_t        rdata_o
);

  entry_t mem [SLOTS];
  entry_t rdata_q;

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/held_key_event_table_core.sv
// top level: list walker and output register of the held key event table
// Held key events live in SLOTS slots of two synchronous memories with one read and one write
// port each (links and entry data); slot 0 heads the active list and is kept in a register,
// free slots form a chain. A request is taken only while the walker is idle. An insert links
// in the free head slot; a remove, query or release walks the active list newest first at one
// slot per cycle unless a key-up waits on the output register (the read latency of the
// memories is hidden by issuing the next read from the link just read), and each unlinked slot
// adds a relink step for its second link write. The worst case is a release of a full table
// plus any result side stalls. Results pass through a one-entry output register, so a new
// request can be taken while the final done result still waits. No clearing pass after reset.
module held_key_event_table_core import hket_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hket_in_if.sink     in_i,
  hket_out_if.source  out_o
);

  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam int unsigned IW = $clog2(SLOTS);
  localparam logic [LW-1:0] SLOT_END = LW'(SLOTS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_INS    = 5'b00010,
    S_WALK   = 5'b00100,
    S_RELINK = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  function automatic logic slot_ok(input logic [LW-1:0] s);
    return (s != '0) && (s < SLOT_END);
  endfunction

  state_e        state_q, state_d;
  op_e           op_q, op_d;
  entry_t        req_q, req_d;
  logic          hit_q, hit_d;
  logic [LW-1:0] head_q, head_d;
  logic [LW-1:0] free_head_q, free_head_d;
  logic [LW-1:0] prev_q, prev_d;
  logic [LW-1:0] cur_q, cur_d;
  logic [LW-1:0] nxt_q, nxt_d;
  logic [LW-1:0] steps_q, steps_d;
  logic [LW-1:0] steps_inc;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          lw_en;
  logic [IW-1:0] lw_addr;
  logic [LW-1:0] lw_data;
  logic          dw_en;
  logic [LW-1:0] lnk;
  entry_t        ent;
  logic          match;

  logic                 out_valid_q;
  logic                 out_free;
  logic                 out_load;
  logic                 ld_kind;
  logic                 ld_hit;
  logic [KEYCODE_W-1:0] ld_keycode;
  logic [KEY_W-1:0]     ld_key;
  logic                 ld_last;
  logic                 kind_q;
  logic                 ohit_q;
  logic [KEYCODE_W-1:0] okeycode_q;
  logic [KEY_W-1:0]     okey_q;
  logic                 last_q;

  // memories
  hket_link_mem #(.SLOTS(SLOTS)) u_link (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .we_i    (lw_en),
    .waddr_i (lw_addr),
    .wdata_i (lw_data),
    .rdata_o (lnk)
  );

  hket_data_mem #(.SLOTS(SLOTS)) u_data (
    .clk_i   (clk_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .we_i    (dw_en),
    .waddr_i (free_head_q[IW-1:0]),
    .wdata_i (req_q),
    .rdata_o (ent)
  );

  // match of the slot just read
  always_comb begin
    case (op_q)
      OP_REMOVE_KEY: match = (ent.key_ref == req_q.key_ref) &&
                             (ent.key_code == req_q.key_code);
      OP_RELEASE:    match = (ent.owner_tag == req_q.owner_tag);
      default:       match = (ent.owner_tag == req_q.owner_tag) &&
                             (ent.key_code == req_q.key_code);
    endcase
  end

  assign steps_inc = steps_q + LW'(1);
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // walker control
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    req_d       = req_q;
    hit_d       = hit_q;
    head_d      = head_q;
    free_head_d = free_head_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    steps_d     = steps_q;
    rd_en       = 1'b0;
    rd_addr     = cur_q[IW-1:0];
    lw_en       = 1'b0;
    lw_addr     = cur_q[IW-1:0];
    lw_data     = free_head_q;
    dw_en       = 1'b0;
    out_load    = 1'b0;
    ld_kind     = KIND_DONE;
    ld_hit      = hit_q;
    ld_keycode  = '0;
    ld_key      = '0;
    ld_last     = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d            = op_e'(in_i.opcode);
          req_d.key_code  = in_i.key_code;
          req_d.key_ref   = in_i.key_ref;
          req_d.owner_tag = in_i.owner_tag;
          hit_d           = 1'b0;
          steps_d         = '0;
          prev_d          = '0;
          cur_d           = head_q;
          state_d         = S_DONE;
          case (op_e'(in_i.opcode))
            OP_INSERT: begin
              if (slot_ok(free_head_q)) begin
                rd_en   = 1'b1;
                rd_addr = free_head_q[IW-1:0];
                state_d = S_INS;
              end
            end
            OP_REMOVE_KEY, OP_RELEASE, OP_QUERY, OP_REMOVE_OWN: begin
              if (slot_ok(head_q)) begin
                rd_en   = 1'b1;
                rd_addr = head_q[IW-1:0];
                state_d = S_WALK;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // link the free head slot in after the sentinel
      S_INS: begin
        lw_en       = 1'b1;
        lw_addr     = free_head_q[IW-1:0];
        lw_data     = head_q;
        dw_en       = 1'b1;
        head_d      = free_head_q;
        free_head_d = lnk;
        hit_d       = 1'b1;
        state_d     = S_DONE;
      end

      // one slot per cycle unless a key-up waits; removed slots go onto the free chain
      S_WALK: begin
        if (match) begin
          if (op_q == OP_QUERY) begin
            hit_d   = 1'b1;
            state_d = S_DONE;
          end else if (op_q != OP_RELEASE || out_free) begin
            if (op_q == OP_RELEASE) begin
              out_load   = 1'b1;
              ld_kind    = KIND_KEYUP;
              ld_hit     = 1'b1;
              ld_keycode = ent.key_code;
              ld_key     = ent.key_ref;
              ld_last    = 1'b0;
            end
            hit_d       = 1'b1;
            steps_d     = steps_inc;
            lw_en       = 1'b1;
            lw_addr     = cur_q[IW-1:0];
            lw_data     = free_head_q;
            free_head_d = cur_q;
            nxt_d       = lnk;
            state_d     = S_RELINK;
          end
        end else begin
          steps_d = steps_inc;
          prev_d  = cur_q;
          cur_d   = lnk;
          if (slot_ok(lnk) && (steps_inc < SLOT_END)) begin
            rd_en   = 1'b1;
            rd_addr = lnk[IW-1:0];
          end else begin
            state_d = S_DONE;
          end
        end
      end

      // predecessor skips the unlinked slot
      S_RELINK: begin
        if (prev_q == '0) begin
          head_d = nxt_q;
        end else begin
          lw_en   = 1'b1;
          lw_addr = prev_q[IW-1:0];
          lw_data = nxt_q;
        end
        state_d = S_DONE;
        if (op_q == OP_RELEASE) begin
          cur_d = nxt_q;
          if (slot_ok(nxt_q) && (steps_q < SLOT_END)) begin
            rd_en   = 1'b1;
            rd_addr = nxt_q[IW-1:0];
            state_d = S_WALK;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= SLOT_END;
      free_head_q <= LW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      free_head_q <= free_head_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request context and walk position
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    req_q   <= req_d;
    hit_q   <= hit_d;
    prev_q  <= prev_d;
    cur_q   <= cur_d;
    nxt_q   <= nxt_d;
    steps_q <= steps_d;
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q     <= ld_kind;
      ohit_q     <= ld_hit;
      okeycode_q <= ld_keycode;
      okey_q     <= ld_key;
      last_q     <= ld_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = kind_q;
  assign out_o.hit         = ohit_q;
  assign out_o.out_keycode = okeycode_q;
  assign out_o.out_key     = okey_q;
  assign out_o.last        = last_q;

  // list heads stay on a slot or at end
  a_heads_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q != '0) && (head_q <= SLOT_END) && (free_head_q != '0) &&
    (free_head_q <= SLOT_END))
    else $error("list head out of range");

  // an accepted insert puts the former free head first on the list
  a_insert_links: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |=> (head_q == $past(free_head_q)))
    else $error("insert did not link the free slot");

  // a walk never goes beyond the pool size
  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (steps_q < SLOT_END))
    else $error("walk ran past the pool size");

  // key-up results are never final, done results always are
  a_last_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (last_q == (kind_q == KIND_DONE)))
    else $error("last flag disagrees with result kind");

  // a done result is loaded only when leaving the done state
  a_done_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && ld_kind == KIND_DONE) |=> (state_q == S_IDLE))
    else $error("done result without return to idle");

endmodule

// File: tb/testbench.sv
// self-checking testbench of the held key event table core
`timescale 1ns / 100ps

module testbench;
  import hket_pkg::*;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned LINK_W    = $clog2(SLOTS + 1);
  localparam int unsigned RAND_REQS = 195;
  localparam int unsigned WDOG_MAX  = 1000;

  // opcodes the block does not define; they must leave the table alone
  localparam logic [OPCODE_W-1:0] OP_UNDEF_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic                 kind;
    logic                 hit;
    logic [KEYCODE_W-1:0] keycode;
    logic [KEY_W-1:0]     key;
    logic                 last;
  } table_result_t;

  logic clk_i;
  logic rst_ni;

  hket_in_if  req_ch ();
  hket_out_if res_ch ();

  held_key_event_table_core #(
    .SLOTS (SLOTS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  // shadow copy of the table
  logic [LINK_W-1:0] link_next [SLOTS];
  entry_t            slot_entry[SLOTS];
  logic [LINK_W-1:0] free_head;

  table_result_t expected_results[$];

  int  mismatch_count = 0;
  int  idle_cycles    = 0;
  int  res_wait       = 0;
  bit  result_taken   = 1'b0;
  bit  calm           = 1'b0;

  // clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic bit is_slot(logic [LINK_W-1:0] s);
    return s != '0 && s < SLOTS;
  endfunction

  function automatic void reset_table();
    for (int i = 0; i < SLOTS; i++) begin
      link_next[i]  = LINK_W'(i + 1);
      slot_entry[i] = '0;
    end
    link_next[0]       = LINK_W'(SLOTS);
    link_next[SLOTS-1] = LINK_W'(SLOTS);
    free_head          = LINK_W'(1);
  endfunction

  function automatic void queue_result(logic kind, logic hit, logic [KEYCODE_W-1:0] kc,
                                       logic [KEY_W-1:0] key, logic last);
    table_result_t r;
    r.kind    = kind;
    r.hit     = hit;
    r.keycode = kc;
    r.key     = key;
    r.last    = last;
    expected_results.push_back(r);
  endfunction

  // take slot cur out of the active list and push it onto the free chain
  function automatic void unlink_slot(logic [LINK_W-1:0] prev, logic [LINK_W-1:0] cur);
    link_next[prev] = link_next[cur];
    link_next[cur]  = free_head;
    free_head       = cur;
  endfunction

  // update the shadow table for one accepted request and queue its results
  function automatic void apply_table_op(logic [OPCODE_W-1:0] op, logic [KEYCODE_W-1:0] kc,
                                         logic [KEY_W-1:0] key, logic [OWNER_W-1:0] own);
    logic              hit;
    logic              hit_now;
    bit                stop;
    int                released;
    int                steps;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] cur;
    logic [LINK_W-1:0] s;
    hit      = 1'b0;
    stop     = 1'b0;
    released = 0;
    steps    = 0;
    prev     = '0;
    cur      = link_next[0];
    if (op == OP_INSERT) begin
      if (is_slot(free_head)) begin
        s                       = free_head;
        free_head               = link_next[s];
        slot_entry[s].key_code  = kc;
        slot_entry[s].key_ref   = key;
        slot_entry[s].owner_tag = own;
        link_next[s]            = link_next[0];
        link_next[0]            = s;
        hit                     = 1'b1;
      end
    end else if (op <= OP_REMOVE_OWN) begin
      // walk newest to oldest
      while (is_slot(cur) && steps < SLOTS && !stop) begin
        steps++;
        case (op)
          OP_REMOVE_KEY: hit_now = slot_entry[cur].key_ref == key &&
                                   slot_entry[cur].key_code == kc;
          OP_RELEASE:    hit_now = slot_entry[cur].owner_tag == own;
          default:       hit_now = slot_entry[cur].owner_tag == own &&
                                   slot_entry[cur].key_code == kc;
        endcase
        if (hit_now) begin
          hit = 1'b1;
          if (op == OP_RELEASE) begin
            if (released < SLOTS - 1) begin
              queue_result(KIND_KEYUP, 1'b1, slot_entry[cur].key_code,
                           slot_entry[cur].key_ref, 1'b0);
              released++;
            end
            unlink_slot(prev, cur);
            cur = link_next[prev];
          end else begin
            if (op != OP_QUERY) unlink_slot(prev, cur);
            stop = 1'b1;
          end
        end else begin
          prev = cur;
          cur  = link_next[cur];
        end
      end
    end
    queue_result(KIND_DONE, hit, '0, '0, 1'b1);
  endfunction

  // random slot on the active list, or -1 when the list is empty
  function automatic int pick_live_slot();
    int                live[$];
    logic [LINK_W-1:0] cur;
    cur = link_next[0];
    while (is_slot(cur) && live.size() < SLOTS) begin
      live.push_back(int'(cur));
      cur = link_next[cur];
    end
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  function automatic void report_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
    $display("%0t: mismatch on %s: expected %h, got %h", $realtime, field, exp_v, got_v);
    mismatch_count++;
  endfunction

  // result checker and acceptance watchdog counter
  always @(posedge clk_i) begin
    table_result_t exp_r;
    if (res_ch.valid && res_ch.ready) begin
      result_taken = 1'b1;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(res_ch.result_kind), 32'(res_ch.out_key));
      end else begin
        exp_r = expected_results.pop_front();
        if (res_ch.result_kind !== exp_r.kind)
          report_mismatch("result_kind", 32'(exp_r.kind), 32'(res_ch.result_kind));
        if (res_ch.hit !== exp_r.hit)
          report_mismatch("hit", 32'(exp_r.hit), 32'(res_ch.hit));
        if (res_ch.out_keycode !== exp_r.keycode)
          report_mismatch("out_keycode", 32'(exp_r.keycode), 32'(res_ch.out_keycode));
        if (res_ch.out_key !== exp_r.key)
          report_mismatch("out_key", exp_r.key, res_ch.out_key);
        if (res_ch.last !== exp_r.last)
          report_mismatch("last", 32'(exp_r.last), 32'(res_ch.last));
      end
    end
    if ((res_ch.valid && res_ch.ready) || (req_ch.valid && req_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
  end

  // result side back-pressure, redrawn after each result
  always @(negedge clk_i) begin
    if (result_taken) begin
      result_taken = 1'b0;
      res_wait     = calm ? 0 : $urandom_range(0, 4);
    end
    if (res_wait > 0) begin
      res_ch.ready <= 1'b0;
      res_wait--;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // watchdog
  initial begin
    while (idle_cycles < WDOG_MAX) @(posedge clk_i);
    $display("%0t: no handshake for %0d cycles", $realtime, WDOG_MAX);
    $display("FAILURE");
    $finish;
  end

  // send one request after a random gap and predict it on acceptance
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [KEYCODE_W-1:0] kc,
                              input logic [KEY_W-1:0] key, input logic [OWNER_W-1:0] own);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_ch.valid     <= 1'b1;
    req_ch.opcode    <= op;
    req_ch.key_code  <= kc;
    req_ch.key_ref   <= key;
    req_ch.owner_tag <= own;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    apply_table_op(op, kc, key, own);
  endtask

  // stop sending until every queued result has come back
  task automatic wait_results_drained();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // no-match paths on an empty table
  task automatic test_empty_table();
    send_request(OP_RELEASE, '0, '0, '0);
    send_request(OP_REMOVE_OWN, '1, '1, '1);
  endtask

  task automatic test_undefined_opcodes();
    for (int op = OP_UNDEF_LO; op <= OP_UNDEF_HI; op++)
      send_request(OP_REMOVE_OWN + OPCODE_W'(op - OP_REMOVE_OWN), 16'h5a5a, 32'hdead_beef,
                   32'h0);
  endtask

  // fill every slot, then one more insert that must be dropped
  task automatic test_fill_and_overflow();
    for (int i = SLOTS - 1; i >= 0; i--)
      send_request(OP_INSERT, KEYCODE_W'(i * 16'h1111), KEY_W'(i * 32'h1111_1111),
                   (i % 3 == 0) ? 32'hffff_ffff : 32'h0);
  endtask

  // query, remove by key and remove by owner on known entries
  task automatic test_match_ops();
    send_request(OP_QUERY, KEYCODE_W'(3 * 16'h1111), 32'h0, 32'hffff_ffff);
    send_request(OP_REMOVE_KEY, KEYCODE_W'(4 * 16'h1111), KEY_W'(4 * 32'h1111_1111), 32'h0);
    send_request(OP_REMOVE_OWN, KEYCODE_W'(6 * 16'h1111), 32'h0, 32'hffff_ffff);
  endtask

  // release every entry of one owner: a long run of key-up results
  task automatic test_release_owner();
    send_request(OP_RELEASE, '0, '0, 32'h0);
  endtask

  // mixed traffic on small value pools so that matches are frequent
  task automatic test_random_traffic();
    logic [KEYCODE_W-1:0] kc_pool [4];
    logic [KEY_W-1:0]     key_pool[4];
    logic [OWNER_W-1:0]   own_pool[3];
    logic [OPCODE_W-1:0]  op;
    logic [KEYCODE_W-1:0] kc;
    logic [KEY_W-1:0]     key;
    logic [OWNER_W-1:0]   own;
    int                   pick;
    int                   live;
    foreach (kc_pool[i])  kc_pool[i]  = KEYCODE_W'($urandom);
    foreach (key_pool[i]) key_pool[i] = $urandom;
    foreach (own_pool[i]) own_pool[i] = $urandom;
    for (int n = 0; n < RAND_REQS; n++) begin
      calm = (n >= 100 && n < 140);
      if (n == 60 || n == 150) wait_results_drained();
      pick = $urandom_range(0, 99);
      if (pick < 38)      op = OP_INSERT;
      else if (pick < 55) op = OP_REMOVE_KEY;
      else if (pick < 65) op = OP_RELEASE;
      else if (pick < 80) op = OP_QUERY;
      else if (pick < 96) op = OP_REMOVE_OWN;
      else                op = OPCODE_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
      kc  = kc_pool[$urandom_range(0, 3)];
      key = key_pool[$urandom_range(0, 3)];
      own = own_pool[$urandom_range(0, 2)];
      // aim most lookups at a live entry
      live = pick_live_slot();
      if (op != OP_INSERT && live >= 0 && $urandom_range(0, 9) < 6) begin
        kc  = slot_entry[live].key_code;
        key = slot_entry[live].key_ref;
        own = slot_entry[live].owner_tag;
      end
      // occasional noise values
      if ($urandom_range(0, 7) == 0) kc  = KEYCODE_W'($urandom);
      if ($urandom_range(0, 7) == 0) key = $urandom;
      if ($urandom_range(0, 7) == 0) own = $urandom;
      send_request(op, kc, key, own);
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni           = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.opcode    = '0;
    req_ch.key_code  = '0;
    req_ch.key_ref   = '0;
    req_ch.owner_tag = '0;
    res_ch.ready     = 1'b0;
    reset_table();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_undefined_opcodes();
    test_fill_and_overflow();
    test_match_ops();
    test_release_owner();
    test_random_traffic();

    // drain, then give late results time to show up
    wait_results_drained();
    repeat (4 * SLOTS) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
